// ===== src/fpcl_pkg.sv =====
package fpcl_pkg;

   // Fixed field widths of the ports
   localparam int LEVEL_W     = 8;
   localparam int PERCENT_W   = 7;
   localparam int REQ_SPEED_W = 16;
   localparam int RSP_SPEED_W = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;

   // Queue entry: {is_query, in_range, level, speed, percent}; speed width is added by users
   localparam int ENTRY_FIXED_W = LEVEL_W + PERCENT_W + 2;
   localparam int QUEUE_DEPTH   = 2;

   // Divide by 99 through a reciprocal multiply
   localparam int DIVISOR     = 99;
   localparam int RECIP_EXTRA = 7;   // 2^7 > 99 keeps the truncated product exact

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_LEVEL = 1'b0,
      CSR_MAX_LEVEL = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_RECORD = 1'b0,
      MODE_QUERY  = 1'b1
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_HI,
      ST_GET_HI,
      ST_CHECK,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_UP,
      ST_DOWN,
      ST_MID,
      ST_MID_WAIT
   } state_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

// ===== src/fpcl_ram.sv =====
module fpcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fpcl_div.sv =====
module fpcl_div #(
   parameter int MAG_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [MAG_W-1:0] dividend,
   output logic             done,
   output logic [MAG_W-1:0] quotient
);

   // x / 99 as (x * ceil(2^SHIFT / 99)) >> SHIFT, exact for any x below 2^MAG_W
   localparam int SHIFT = MAG_W + fpcl_pkg::RECIP_EXTRA;
   localparam int RW    = MAG_W + 1;
   localparam int PW    = MAG_W + RW;
   localparam logic [RW-1:0] RECIP =
      RW'(((64'd1 << SHIFT) + 64'(fpcl_pkg::DIVISOR - 1)) / 64'(fpcl_pkg::DIVISOR));

   logic             step_ff, step_in;
   logic             done_ff, done_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [MAG_W-1:0] quo_ff, quo_in;

   // multiply on start into a register, shift in the next cycle
   always_comb begin
      step_in = start;
      done_in = step_ff;
      prod_in = prod_ff;
      quo_in  = quo_ff;
      if (start) begin
         prod_in = PW'(dividend) * PW'(RECIP);
      end
      if (step_ff) begin
         quo_in = MAG_W'(prod_ff[PW-1:SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/fpcl_queue.sv =====
module fpcl_queue #(
   parameter int WIDTH = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output fpcl_pkg::queue_status_type status
);

   localparam int DEPTH = fpcl_pkg::QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(DEPTH));

endmodule

// ===== src/fpcl_front.sv =====
module fpcl_front #(
   parameter int LEVELS     = 256,
   parameter int SPEED_BITS = 16
) (
   input  logic                                        start,
   output logic                                        busy,
   input  logic                                        req_mode,
   input  logic [fpcl_pkg::LEVEL_W-1:0]                req_level,
   input  logic [fpcl_pkg::REQ_SPEED_W-1:0]            req_speed,
   input  logic [fpcl_pkg::PERCENT_W-1:0]              req_percent,
   input  fpcl_pkg::queue_status_type                  queue_status,
   input  fpcl_pkg::back_status_type                   back_status,
   output logic                                        push,
   output logic [SPEED_BITS+fpcl_pkg::ENTRY_FIXED_W-1:0] push_data
);

   logic                  is_query;
   logic                  in_range;
   logic                  over;
   logic [SPEED_BITS-1:0] speed_sat;

   assign busy = back_status.clearing || queue_status.full;
   assign push = start && !busy;

   assign is_query  = (req_mode == fpcl_pkg::MODE_QUERY);
   // records beyond the table are dropped by the back end
   assign in_range  = int'(req_level) < LEVELS;
   assign over      = int'(req_speed) > ((2 ** SPEED_BITS) - 1);
   assign speed_sat = over ? '1 : SPEED_BITS'(req_speed);

   assign push_data = {is_query, in_range, req_level, speed_sat, req_percent};

endmodule

// ===== src/fpcl_back.sv =====
module fpcl_back #(
   parameter int LEVELS     = 256,
   parameter int SPEED_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [fpcl_pkg::LEVEL_W-1:0]                  min_level,
   input  logic [fpcl_pkg::LEVEL_W-1:0]                  max_level,
   input  fpcl_pkg::queue_status_type                    queue_status,
   input  logic [SPEED_BITS+fpcl_pkg::ENTRY_FIXED_W-1:0] pop_data,
   output logic                                          pop,
   output fpcl_pkg::back_status_type                     back_status,
   output logic                                          rsp_strobe,
   output logic [fpcl_pkg::LEVEL_W-1:0]                  rsp_chosen_level,
   output logic [fpcl_pkg::RSP_SPEED_W-1:0]              rsp_chosen_speed
);

   localparam int SB     = SPEED_BITS;
   localparam int IDX_W  = $clog2(LEVELS);
   localparam int LW     = fpcl_pkg::LEVEL_W;
   localparam int PW     = fpcl_pkg::PERCENT_W;
   localparam int OW     = fpcl_pkg::RSP_SPEED_W;
   localparam int PROD_W = SB + 9;
   localparam int MAG_W  = PROD_W - 1;
   localparam int TGT_W  = SB + 3;
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(LEVELS - 1);

   fpcl_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]         clr_ff, clr_in;
   logic [PW-1:0]            pct_ff, pct_in;
   logic [SB-1:0]            lo_ff, lo_in;
   logic [SB-1:0]            hi_ff, hi_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     neg_ff, neg_in;
   logic signed [TGT_W-1:0]  target_ff, target_in;
   logic [LW-1:0]            a_ff, a_in;
   logic [LW-1:0]            b_ff, b_in;
   logic [LW-1:0]            i_ff, i_in;
   logic [LW-1:0]            pi_ff, pi_in;
   logic [LW-1:0]            mid_ff, mid_in;
   logic                     pv_ff, pv_in;
   logic                     rd_ok_ff, rd_ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]            rsp_level_ff, rsp_level_in;
   logic [OW-1:0]            rsp_speed_ff, rsp_speed_in;

   // queue head
   logic [PW-1:0] e_percent;
   logic [SB-1:0] e_speed;
   logic [LW-1:0] e_level;
   logic          e_in_range;
   logic          e_is_query;

   // table port
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [SB-1:0]    wr_data;
   logic [LW-1:0]    rd_idx;
   logic [SB-1:0]    rd_data;

   // datapath
   logic [SB-1:0]            v;
   logic                     v_nz;
   logic signed [TGT_W-1:0]  v_s;
   logic signed [7:0]        pct_m1;
   logic signed [SB:0]       diff;
   logic signed [PROD_W-1:0] prod_neg;
   logic [MAG_W-1:0]         mag;
   logic signed [TGT_W-1:0]  q_s;
   logic [LW:0]              mid_sum;
   logic                     up_issue, up_break, up_end;
   logic                     down_issue, down_break, down_end;
   logic                     div_start, div_done;
   logic [MAG_W-1:0]         div_quotient;

   assign e_percent  = pop_data[PW-1:0];
   assign e_speed    = pop_data[PW+SB-1:PW];
   assign e_level    = pop_data[PW+SB+LW-1:PW+SB];
   assign e_in_range = pop_data[PW+SB+LW];
   assign e_is_query = pop_data[PW+SB+LW+1];

   fpcl_ram #(
      .WIDTH (SB),
      .DEPTH (LEVELS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (IDX_W'(rd_idx)),
      .rd_data (rd_data)
   );

   fpcl_div #(
      .MAG_W (MAG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // levels beyond the table read as unmeasured
   assign rd_ok_in = int'(rd_idx) < LEVELS;
   assign v        = rd_ok_ff ? rd_data : '0;
   assign v_nz     = |v;
   assign v_s      = $signed({3'b000, v});

   assign pct_m1   = $signed({1'b0, pct_ff}) - 8'sd1;
   assign diff     = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
   assign prod_neg = -prod_ff;
   assign mag      = prod_ff[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_ff[MAG_W-1:0];
   assign q_s      = $signed({1'b0, div_quotient[TGT_W-2:0]});
   assign mid_sum  = {1'b0, a_ff} + {1'b0, b_ff};

   // scans: one read issued per cycle, the previous read judged alongside
   assign up_issue   = i_ff < b_ff;
   assign up_break   = pv_ff && v_nz && (v_s >= target_ff);
   assign up_end     = up_break || (!pv_ff && !up_issue);
   assign down_issue = i_ff > a_ff;
   assign down_break = pv_ff && v_nz && (v_s <= target_ff);
   assign down_end   = down_break || (!pv_ff && !down_issue);

   always_comb begin
      case (state_ff)
         fpcl_pkg::ST_CLEAR:
            state_in = (clr_ff == CLR_LAST) ? fpcl_pkg::ST_IDLE : fpcl_pkg::ST_CLEAR;
         fpcl_pkg::ST_IDLE:
            state_in = (!queue_status.empty && e_is_query) ? fpcl_pkg::ST_RD_HI
                                                           : fpcl_pkg::ST_IDLE;
         fpcl_pkg::ST_RD_HI:  state_in = fpcl_pkg::ST_GET_HI;
         fpcl_pkg::ST_GET_HI: state_in = fpcl_pkg::ST_CHECK;
         fpcl_pkg::ST_CHECK:
            state_in = ((lo_ff == '0) || (hi_ff == '0)) ? fpcl_pkg::ST_IDLE
                                                        : fpcl_pkg::ST_DIV_GO;
         fpcl_pkg::ST_DIV_GO: state_in = fpcl_pkg::ST_DIV_WAIT;
         fpcl_pkg::ST_DIV_WAIT:
            state_in = div_done ? fpcl_pkg::ST_UP : fpcl_pkg::ST_DIV_WAIT;
         fpcl_pkg::ST_UP:
            state_in = up_end ? fpcl_pkg::ST_DOWN : fpcl_pkg::ST_UP;
         fpcl_pkg::ST_DOWN:
            state_in = down_end ? fpcl_pkg::ST_MID : fpcl_pkg::ST_DOWN;
         fpcl_pkg::ST_MID:      state_in = fpcl_pkg::ST_MID_WAIT;
         fpcl_pkg::ST_MID_WAIT: state_in = fpcl_pkg::ST_IDLE;
         default:               state_in = fpcl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      clr_in       = clr_ff;
      pct_in       = pct_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      target_in    = target_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      i_in         = i_ff;
      pi_in        = pi_ff;
      mid_in       = mid_ff;
      pv_in        = pv_ff;
      rsp_valid_in = 1'b0;
      rsp_level_in = rsp_level_ff;
      rsp_speed_in = rsp_speed_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      rd_idx       = i_ff;
      pop          = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         fpcl_pkg::ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
         end
         fpcl_pkg::ST_IDLE: begin
            rd_idx = min_level;
            if (!queue_status.empty) begin
               pop = 1'b1;
               if (e_is_query) begin
                  pct_in = e_percent;
               end else if (e_in_range) begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(e_level);
                  wr_data = e_speed;
               end
            end
         end
         fpcl_pkg::ST_RD_HI: begin
            rd_idx = max_level;
            lo_in  = v;
         end
         fpcl_pkg::ST_GET_HI: begin
            hi_in = v;
         end
         fpcl_pkg::ST_CHECK: begin
            prod_in = pct_m1 * diff;
            if (lo_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = min_level;
               rsp_speed_in = '0;
            end else if (hi_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = max_level;
               rsp_speed_in = '0;
            end
         end
         fpcl_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            neg_in    = prod_ff[PROD_W-1];
         end
         fpcl_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               target_in = $signed({3'b000, lo_ff}) + (neg_ff ? -q_s : q_s);
               i_in      = min_level;
               a_in      = min_level;
               b_in      = max_level;
               pv_in     = 1'b0;
            end
         end
         fpcl_pkg::ST_UP: begin
            if (pv_ff && v_nz && !up_break) begin
               a_in = pi_ff;
            end
            if (up_end) begin
               i_in  = max_level;
               pv_in = 1'b0;
            end else begin
               pv_in = up_issue;
               if (up_issue) begin
                  pi_in = i_ff;
                  i_in  = i_ff + LW'(1);
               end
            end
         end
         fpcl_pkg::ST_DOWN: begin
            if (pv_ff && v_nz && !down_break) begin
               b_in = pi_ff;
            end
            if (down_end) begin
               pv_in = 1'b0;
            end else begin
               pv_in = down_issue;
               if (down_issue) begin
                  pi_in = i_ff;
                  i_in  = i_ff - LW'(1);
               end
            end
         end
         fpcl_pkg::ST_MID: begin
            rd_idx = mid_sum[LW:1];
            mid_in = mid_sum[LW:1];
         end
         fpcl_pkg::ST_MID_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_level_in = mid_ff;
            rsp_speed_in = OW'(v);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fpcl_pkg::ST_CLEAR;
         clr_ff       <= '0;
         pv_ff        <= 1'b0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pv_ff        <= pv_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pct_ff       <= pct_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      prod_ff      <= prod_in;
      neg_ff       <= neg_in;
      target_ff    <= target_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      i_ff         <= i_in;
      pi_ff        <= pi_in;
      mid_ff       <= mid_in;
      rsp_level_ff <= rsp_level_in;
      rsp_speed_ff <= rsp_speed_in;
   end

   assign back_status.clearing = (state_ff == fpcl_pkg::ST_CLEAR);
   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_chosen_level     = rsp_level_ff;
   assign rsp_chosen_speed     = rsp_speed_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == fpcl_pkg::ST_CHECK ||
                        $past(state_ff) == fpcl_pkg::ST_MID_WAIT))
      else $error("result strobe outside a finishing step");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fpcl_pkg::ST_UP || state_ff == fpcl_pkg::ST_DOWN) |-> !wr_en)
      else $error("table written during a scan");

   a_lower_rises: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fpcl_pkg::ST_UP) |=> (a_ff >= $past(a_ff)))
      else $error("lower point moved down in upward scan");

   a_upper_falls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fpcl_pkg::ST_DOWN) |=> (b_ff <= $past(b_ff)))
      else $error("upper point moved up in downward scan");

   a_clear_queue_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fpcl_pkg::ST_CLEAR) |-> queue_status.empty)
      else $error("item queued during clearing pass");

endmodule

// ===== src/fan_pwm_calibration_lookup.sv =====
// Fan PWM calibration lookup. Keeps a table of measured fan speed per PWM level (zero means
// unmeasured). An item is taken at a clock edge with start high and busy low. A record item
// (req_mode 0) stores req_speed, saturated to the table width, at req_level and gives no
// result; levels beyond the table are dropped. A query item (req_mode 1) gives exactly one
// result: rsp_strobe is high for one cycle with rsp_chosen_level and rsp_chosen_speed, and
// the receiver cannot hold it off. Items pass through a two-entry queue, so busy rises only
// when the queue is full or while the table is being cleared. After reset a clearing pass
// writes zero to every entry with busy high; min_level/max_level may be written through the
// csr_ port at any time the block is idle. The back end stores a record in the same cycle
// that it pops it from the queue. A query holds the back end while it reads the two bound
// entries, divides by 99 through a reciprocal multiply and scans the table (upward from
// min_level, then downward from max_level, one table read a cycle through the single read
// port). A query whose bound entry is unmeasured ends at the bound check, without the
// division or the scans.
module fan_pwm_calibration_lookup #(
   parameter int LEVELS     = 256,
   parameter int SPEED_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_mode,
   input  logic [fpcl_pkg::LEVEL_W-1:0]       req_level,
   input  logic [fpcl_pkg::REQ_SPEED_W-1:0]   req_speed,
   input  logic [fpcl_pkg::PERCENT_W-1:0]     req_percent,
   output logic                               rsp_strobe,
   output logic [fpcl_pkg::LEVEL_W-1:0]       rsp_chosen_level,
   output logic [fpcl_pkg::RSP_SPEED_W-1:0]   rsp_chosen_speed,
   input  logic                               csr_we,
   input  logic [fpcl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fpcl_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int ENTRY_W = SPEED_BITS + fpcl_pkg::ENTRY_FIXED_W;
   localparam int LW      = fpcl_pkg::LEVEL_W;

   // search bounds
   logic [LW-1:0] min_level_ff, min_level_in;
   logic [LW-1:0] max_level_ff, max_level_in;

   // front to queue
   logic               push;
   logic [ENTRY_W-1:0] push_data;

   // queue to back
   logic                       pop;
   logic [ENTRY_W-1:0]         pop_data;
   fpcl_pkg::queue_status_type queue_status;
   fpcl_pkg::back_status_type  back_status;

   always_comb begin
      min_level_in = min_level_ff;
      max_level_in = max_level_ff;
      if (csr_we) begin
         case (fpcl_pkg::csr_index_type'(csr_index))
            fpcl_pkg::CSR_MIN_LEVEL: min_level_in = csr_data;
            fpcl_pkg::CSR_MAX_LEVEL: max_level_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff <= '0;
         max_level_ff <= '1;
      end else begin
         min_level_ff <= min_level_in;
         max_level_ff <= max_level_in;
      end
   end

   // front: takes items, sorts record from query, saturates the speed
   fpcl_front #(
      .LEVELS     (LEVELS),
      .SPEED_BITS (SPEED_BITS)
   ) u_front (
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_level    (req_level),
      .req_speed    (req_speed),
      .req_percent  (req_percent),
      .queue_status (queue_status),
      .back_status  (back_status),
      .push         (push),
      .push_data    (push_data)
   );

   // short queue so the front keeps taking items while a query scans
   fpcl_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   // back: owns the table, runs the clearing pass, records and the query sequencer
   fpcl_back #(
      .LEVELS     (LEVELS),
      .SPEED_BITS (SPEED_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .min_level        (min_level_ff),
      .max_level        (max_level_ff),
      .queue_status     (queue_status),
      .pop_data         (pop_data),
      .pop              (pop),
      .back_status      (back_status),
      .rsp_strobe       (rsp_strobe),
      .rsp_chosen_level (rsp_chosen_level),
      .rsp_chosen_speed (rsp_chosen_speed)
   );

endmodule
